[sv/pfcm_pkg.sv]
// Package for the mono pixel format converter: config types, register
// indexes and the mask geometry / field rescale helpers. No dependencies.
`timescale 1ns / 1ps

package pfcm_pkg;

    localparam int PIX_W  = 32;
    localparam int OFF_W  = 5;   // bit position inside a pixel word
    localparam int DEP_W  = 6;   // field depth, 0 .. 32
    localparam int CH_W   = 8;   // destination channel width
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] REG_SRC_RED   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SRC_BLUE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DST_RED   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DST_GREEN = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DST_BLUE  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_DST_ALPHA = 3'd5;

    localparam logic [PIX_W-1:0] RST_SRC_RED   = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_SRC_BLUE  = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] RST_DST_RED   = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_DST_GREEN = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_DST_BLUE  = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] RST_DST_ALPHA = 32'hFF00_0000;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [DEP_W-1:0] depth;
    } t_geom;

    // Everything the pixel path needs, derived from the config registers.
    typedef struct packed {
        logic [PIX_W-1:0] src_red_mask;
        t_geom            src_red;
        logic [PIX_W-1:0] src_blue_mask;
        t_geom            src_blue;
        t_geom            dst_red;
        logic [OFF_W-1:0] dst_green_off;
        t_geom            dst_blue;
        logic [PIX_W-1:0] dst_alpha_mask;
    } t_cfg;

    // Index of the lowest set bit (0 for a zero word).
    function automatic logic [OFF_W-1:0] f_low_index(input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] iso;
        logic [OFF_W-1:0] idx;
        iso = m & (~m + {{(PIX_W-1){1'b0}}, 1'b1});
        idx = '0;
        for (int k = 0; k < PIX_W; k++) begin
            if (iso[k]) begin
                idx = idx | OFF_W'(k);
            end
        end
        return idx;
    endfunction

    // Offset and depth of a channel mask; holes inside the mask count.
    function automatic t_geom f_geom(input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] rev;
        logic [OFF_W-1:0] msb;
        t_geom            g;
        for (int k = 0; k < PIX_W; k++) begin
            rev[k] = m[PIX_W-1-k];
        end
        g.off = f_low_index(m);
        msb   = OFF_W'(PIX_W - 1) - f_low_index(rev);
        if (m == '0) begin
            g.depth = '0;
        end else begin
            g.depth = {1'b0, msb} - {1'b0, g.off} + DEP_W'(1);
        end
        return g;
    endfunction

    // Rescale a field from depth sd to depth dd; low channel bits only.
    function automatic logic [CH_W-1:0] f_rescale(input logic [PIX_W-1:0] v,
                                                   input logic [DEP_W-1:0] sd,
                                                   input logic [DEP_W-1:0] dd);
        logic [DEP_W-1:0] hi;
        logic [DEP_W-1:0] lo;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] dn;
        logic [CH_W-1:0]  res;
        hi = dd - sd;
        lo = '0;
        up = '0;
        dn = '0;
        if (sd < dd) begin
            // widen: replicate the top bits into the freed low bits
            lo  = (sd > hi) ? (sd - hi) : '0;
            up  = v << hi;
            dn  = v >> lo;
            res = up[CH_W-1:0] | dn[CH_W-1:0];
        end else if (sd > dd) begin
            dn  = v >> (sd - dd);
            res = dn[CH_W-1:0];
        end else begin
            res = v[CH_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/pfcm_cfg_regs.sv]
// Config register file of the mono pixel converter; mask geometry is
// worked out from the write data so it is valid with the mask. Uses pfcm_pkg.
`timescale 1ns / 1ps

module pfcm_cfg_regs
    import pfcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [PIX_W-1:0]  i_cfg_wdata,
    output t_cfg              o_cfg
);

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_geom w_geom;

    assign w_geom = f_geom(i_cfg_wdata);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SRC_RED: begin
                    n_cfg.src_red_mask = i_cfg_wdata;
                    n_cfg.src_red      = w_geom;
                end
                REG_SRC_BLUE: begin
                    n_cfg.src_blue_mask = i_cfg_wdata;
                    n_cfg.src_blue      = w_geom;
                end
                REG_DST_RED:   n_cfg.dst_red        = w_geom;
                REG_DST_GREEN: n_cfg.dst_green_off  = w_geom.off;
                REG_DST_BLUE:  n_cfg.dst_blue       = w_geom;
                REG_DST_ALPHA: n_cfg.dst_alpha_mask = i_cfg_wdata;
                default:       n_cfg = r_cfg;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_red_mask   <= RST_SRC_RED;
            r_cfg.src_red        <= f_geom(RST_SRC_RED);
            r_cfg.src_blue_mask  <= RST_SRC_BLUE;
            r_cfg.src_blue       <= f_geom(RST_SRC_BLUE);
            r_cfg.dst_red        <= f_geom(RST_DST_RED);
            r_cfg.dst_green_off  <= f_low_index(RST_DST_GREEN);
            r_cfg.dst_blue       <= f_geom(RST_DST_BLUE);
            r_cfg.dst_alpha_mask <= RST_DST_ALPHA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/pfcm_convert.sv]
// Combinational pixel path: extract red and blue, rescale, average to grey
// and place it in every colour field over the alpha mask. Uses pfcm_pkg.
`timescale 1ns / 1ps

module pfcm_convert
    import pfcm_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_pix,
    output logic [PIX_W-1:0] o_pix
);

    logic [PIX_W-1:0] w_red_raw;
    logic [PIX_W-1:0] w_blue_raw;
    logic [CH_W-1:0]  w_red;
    logic [CH_W-1:0]  w_blue;
    logic [CH_W:0]    w_sum;
    logic [PIX_W-1:0] w_grey;

    assign w_red_raw  = (i_pix & i_cfg.src_red_mask) >> i_cfg.src_red.off;
    assign w_blue_raw = (i_pix & i_cfg.src_blue_mask) >> i_cfg.src_blue.off;

    assign w_red  = f_rescale(w_red_raw, i_cfg.src_red.depth, i_cfg.dst_red.depth);
    assign w_blue = f_rescale(w_blue_raw, i_cfg.src_blue.depth, i_cfg.dst_blue.depth);

    assign w_sum  = {1'b0, w_red} + {1'b0, w_blue};
    assign w_grey = {{(PIX_W-CH_W){1'b0}}, w_sum[CH_W:1]};

    // grey is not clipped to the field depth; bits past the top are dropped
    assign o_pix = i_cfg.dst_alpha_mask
                 | (w_grey << i_cfg.dst_red.off)
                 | (w_grey << i_cfg.dst_green_off)
                 | (w_grey << i_cfg.dst_blue.off);

endmodule

[sv/pixel_format_convert_mono_core.sv]
// Top level of the mono pixel format converter: stream ports, input and
// result registers. Uses pfcm_pkg, pfcm_cfg_regs and pfcm_convert.
//
// Usage:
//   Source words enter on the s_axis channel, converted words leave on the
//   m_axis channel, both accepted when tvalid and tready are high together.
//   Each source word gives exactly one destination word, in order.
//   An accepted source word goes into the input register, then through the
//   converter into the result register, which drives o_m_axis_tvalid.
//   Throughput is one word per cycle: the input register moves on whenever
//   the result register is empty or being taken, so both stages advance
//   every cycle while the receiver keeps tready high.
//   When the receiver holds i_m_axis_tready low the result register holds,
//   the input register still takes one more word, and then o_s_axis_tready
//   drops until the result is taken.
//   Mask registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while no word is in flight; offset and depth are worked out on write.
//   Reset (synchronous, active low) empties both registers and restores
//   the default 32-bit ARGB masks.
`timescale 1ns / 1ps

module pixel_format_convert_mono_core
    import pfcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [PIX_W-1:0]  i_s_axis_tdata,   // [31:0] in_pixel
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [PIX_W-1:0]  o_m_axis_tdata,   // [31:0] out_pixel
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [PIX_W-1:0]  i_cfg_wdata
);

    t_cfg             w_cfg;
    logic             r_in_valid;
    logic [PIX_W-1:0] r_in_pix;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic [PIX_W-1:0] w_conv_pix;
    logic             w_out_load;
    logic             w_in_load;

    pfcm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pfcm_convert u_conv (
        .i_cfg (w_cfg),
        .i_pix (r_in_pix),
        .o_pix (w_conv_pix)
    );

    // result register frees up when empty or being taken this cycle
    assign w_out_load      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_out_load;
    assign w_in_load       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_pix <= i_s_axis_tdata;
        end
        if (w_out_load && r_in_valid) begin
            r_out_pix <= w_conv_pix;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;

endmodule

[sv/pfcm_checker.sv]
// Port-level checks for the mono pixel converter, bound to the top level.
// Uses pfcm_pkg for widths.
`timescale 1ns / 1ps

module pfcm_checker
    import pfcm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [PIX_W-1:0] o_m_axis_tdata
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // an accepted word is followed by output valid once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> ##1 o_m_axis_tvalid)
        else $error("accepted word did not reach the output");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind pixel_format_convert_mono_core pfcm_checker u_pfcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
